// ===== src/cilm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic line minimizer package
// Shared types, default constants and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package cilm_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int MAX_ITER_DEF  = 64;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

	// Operations of the shared arithmetic unit.
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MULQ,
		OP_MULI,
		OP_DIV,
		OP_SQRT
	} alu_op_t;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// Internal states of the arithmetic unit.
	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_MFIN,
		A_DIV,
		A_DFIN,
		A_SQRT,
		A_SFIN
	} alu_st_t;

	// Search phase: which function value the block waits for.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_F0,
		PH_F3,
		PH_F1,
		PH_F2
	} phase_t;

	// Sequencer states.
	typedef enum logic [5:0] {
		S_WAIT, S_LIM, S_M0, S_M1, S_M2,
		S_TH0, S_TH1, S_TH2,
		S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10, S_C11, S_C12,
		S_C13, S_BR,
		S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D8, S_D9, S_D10, S_D11,
		S_D12, S_D13, S_D14,
		S_Q0, S_Q1, S_Q2,
		S_Y, S_Y1,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
		S_X0, S_X1, S_X2, S_X3, S_X4, S_X5,
		S_S0, S_S1, S_S2, S_S3,
		S_F0, S_F1, S_F2,
		S_EMIT
	} seq_t;

	// Destination register of an arithmetic result.
	typedef enum logic [4:0] {
		D_TA, D_TB, D_S1, D_S3, D_D1, D_D3, D_C3, D_C2, D_C1, D_K0, D_K2,
		D_U1, D_U2, D_U, D_P, D_W, D_XS, D_PREV, D_RESX
	} dst_t;

	// Magnitude of a signed value as an unsigned word.
	function automatic logic [63:0] mag(input logic signed [63:0] a);
		mag = a[63] ? (64'd0 - 64'(a)) : 64'(a);
	endfunction

	// Signed value from a sign and a magnitude, saturated.
	function automatic logic signed [63:0] from_mag(input logic neg, input logic ovf,
		input logic [63:0] m);
		if (neg) begin
			if (ovf || (m > 64'h8000_0000_0000_0000)) from_mag = SMIN;
			else from_mag = 64'(64'd0 - m);
		end else begin
			if (ovf || m[63]) from_mag = SMAX;
			else from_mag = 64'(m);
		end
	endfunction

	// Saturating add.
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) sat_add = s[64] ? SMIN : SMAX;
		else sat_add = s[63:0];
	endfunction

	// Saturating subtract.
	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) sat_sub = s[64] ? SMIN : SMAX;
		else sat_sub = s[63:0];
	endfunction

endpackage

// ===== src/cilm_alu.sv =====
// ----------------------------------------------------------------------------
// Cubic line minimizer arithmetic unit
// Shared saturating add, subtract, 32x32-partial multiply, radix-2 divide
// and digit-by-digit square root on signed fixed-point words.
// ----------------------------------------------------------------------------
module cilm_alu #(
	parameter int FRAC_BITS = cilm_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cilm_pkg::alu_req_t     req,
	input  logic signed [63:0]     a,
	input  logic signed [63:0]     b,
	output logic                   done,
	output logic signed [63:0]     res
);

	cilm_pkg::alu_st_t st_q;
	cilm_pkg::alu_op_t op_q;
	logic              done_q;
	logic signed [63:0] res_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [127:0] n_q;
	logic [63:0]  rem_q;
	logic [63:0]  quo_q;
	logic         ovf_q;
	logic [66:0]  srem_q;
	logic [63:0]  root_q;
	logic [6:0]   cnt_q;

	logic [31:0]  ha, hb;
	logic [63:0]  pp;
	logic [1:0]   sh;
	logic [127:0] rnd;
	logic [127:0] mq;
	logic [64:0]  rem_n;
	logic         dge;
	logic [66:0]  srem_n;
	logic [66:0]  trial;
	logic         sge;
	logic [63:0]  bmag;

	// One partial product per cycle.
	assign ha  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign hb  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp  = ha * hb;
	assign sh  = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
	assign rnd = acc_q + (128'd1 << (FRAC_BITS - 1));
	assign mq  = (op_q == cilm_pkg::OP_MULQ) ? (rnd >> FRAC_BITS) : acc_q;

	// Divider step.
	assign rem_n = {rem_q, n_q[127]};
	assign dge   = rem_n >= {1'b0, mb_q};

	// Square-root step.
	assign srem_n = {srem_q[64:0], n_q[127:126]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign sge    = srem_n >= trial;

	assign bmag = cilm_pkg::mag(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= cilm_pkg::A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				cilm_pkg::A_IDLE: begin
					if (req.start) begin
						case (req.op)
							cilm_pkg::OP_ADD: begin
								done_q <= 1'b1;
							end
							cilm_pkg::OP_SUB: begin
								done_q <= 1'b1;
							end
							cilm_pkg::OP_MULQ, cilm_pkg::OP_MULI: begin
								st_q <= cilm_pkg::A_MUL;
							end
							cilm_pkg::OP_DIV: begin
								if (b == 64'sd0) done_q <= 1'b1;
								else st_q <= cilm_pkg::A_DIV;
							end
							cilm_pkg::OP_SQRT: begin
								st_q <= cilm_pkg::A_SQRT;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				cilm_pkg::A_MUL: begin
					if (cnt_q == 7'd3) st_q <= cilm_pkg::A_MFIN;
				end
				cilm_pkg::A_DIV: begin
					if (cnt_q == 7'd127) st_q <= cilm_pkg::A_DFIN;
				end
				cilm_pkg::A_SQRT: begin
					if (cnt_q == 7'd63) st_q <= cilm_pkg::A_SFIN;
				end
				cilm_pkg::A_MFIN, cilm_pkg::A_DFIN, cilm_pkg::A_SFIN: begin
					st_q   <= cilm_pkg::A_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					st_q <= cilm_pkg::A_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			cilm_pkg::A_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					cnt_q <= 7'd0;
					neg_q <= a[63] ^ b[63];
					ma_q  <= cilm_pkg::mag(a);
					mb_q  <= bmag;
					acc_q <= 128'd0;
					rem_q <= 64'd0;
					quo_q <= 64'd0;
					ovf_q <= 1'b0;
					srem_q <= 67'd0;
					root_q <= 64'd0;
					case (req.op)
						cilm_pkg::OP_ADD: res_q <= cilm_pkg::sat_add(a, b);
						cilm_pkg::OP_SUB: res_q <= cilm_pkg::sat_sub(a, b);
						cilm_pkg::OP_DIV: begin
							n_q <= (128'(cilm_pkg::mag(a)) << FRAC_BITS) + 128'(bmag >> 1);
							if (a == 64'sd0) res_q <= 64'sd0;
							else res_q <= a[63] ? cilm_pkg::SMIN : cilm_pkg::SMAX;
						end
						cilm_pkg::OP_SQRT: begin
							n_q <= (a[63] ? 128'd0 : 128'(a)) << FRAC_BITS;
						end
						default: res_q <= 64'sd0;
					endcase
				end
			end
			cilm_pkg::A_MUL: begin
				acc_q <= acc_q + ({64'd0, pp} << {sh, 5'd0});
				cnt_q <= cnt_q + 7'd1;
			end
			cilm_pkg::A_MFIN: begin
				res_q <= cilm_pkg::from_mag(neg_q, |mq[127:64], mq[63:0]);
			end
			cilm_pkg::A_DIV: begin
				rem_q <= dge ? 64'(rem_n - {1'b0, mb_q}) : rem_n[63:0];
				n_q   <= {n_q[126:0], 1'b0};
				ovf_q <= ovf_q | quo_q[63];
				quo_q <= {quo_q[62:0], dge};
				cnt_q <= cnt_q + 7'd1;
			end
			cilm_pkg::A_DFIN: begin
				res_q <= cilm_pkg::from_mag(neg_q, ovf_q, quo_q);
			end
			cilm_pkg::A_SQRT: begin
				srem_q <= sge ? (srem_n - trial) : srem_n;
				root_q <= {root_q[62:0], sge};
				n_q    <= {n_q[125:0], 2'b00};
				cnt_q  <= cnt_q + 7'd1;
			end
			cilm_pkg::A_SFIN: begin
				res_q <= root_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== src/cubic_interpolation_line_minimizer.sv =====
// ----------------------------------------------------------------------------
// Cubic interpolation line minimizer
// Brackets a minimum of an externally evaluated function by cubic fits.
// ----------------------------------------------------------------------------
// Usage: write interval_start, interval_end and tolerance on the cfg port
// while the block is idle. An input item with tuser = 0 starts a search and
// is answered with the first abscissa to evaluate; every item with tuser = 1
// carries f at the last abscissa and is answered with the next abscissa, or
// with the minimizer and tuser = 1 on the output when the search is done.
// Exactly one result item follows each input item.
// Items for f(x0) and other items that need no arithmetic are answered
// directly. The start item counts its shrink passes and then uses the
// shared arithmetic unit, as do the third-point items and the item after
// f(x2): a radix-2 divider, a digit-by-digit square root and a multiplier
// that sums four 32x32 partial products.
// The block takes one item at a time; s_tready is low while it works. A
// finished result waits in the output register, and the next input item is
// already taken while it waits. When the receiver stalls, the block holds
// the following result until the output register frees.
// Reset clears the search to idle, the output valid flag and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module cubic_interpolation_line_minimizer #(
	parameter int FRAC_BITS = cilm_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITER  = cilm_pkg::MAX_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] function_value
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] query_x, [70:64] iteration, [71] zero
	output logic        m_tuser,   // [0] finished
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_TOL   = 2'd2;

	localparam logic signed [63:0] Q2 = 64'sd2 <<< FRAC_BITS;
	localparam logic signed [63:0] Q3 = 64'sd3 <<< FRAC_BITS;
	localparam logic signed [63:0] Q6 = 64'sd6 <<< FRAC_BITS;
	localparam logic signed [63:0] NQ3 = -Q3;
	localparam logic signed [63:0] ZERO = 64'sd0;
	localparam logic signed [63:0] K3  = 64'sd3;
	localparam logic signed [63:0] K6  = 64'sd6;
	localparam logic signed [63:0] K27 = 64'sd27;
	localparam logic signed [63:0] K48 = 64'sd48;
	localparam logic [63:0] T3 =
		(64'd37660237078 + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
	localparam logic [63:0] T2 =
		(64'd35962877333 + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
	localparam logic [6:0] ITER_CAP = 7'(MAX_ITER);

	// Configuration registers.
	logic signed [63:0] istart_q, iend_q;
	logic [62:0]        tol_q;

	// Search state.
	cilm_pkg::seq_t     st_q, st_d;
	cilm_pkg::phase_t   phase_q;
	logic               issued_q;
	logic signed [63:0] bl_q, br_q, vl_q, vr_q, vi1_q, prev_q, f2_q;
	logic [6:0]         pcnt_q, plim_q, n_q;
	logic [63:0]        width_q, cur_q;
	logic               right_q;
	cilm_pkg::seq_t     ret_q;

	// Fit temporaries.
	logic signed [63:0] ta_q, tb_q, s1_q, s3_q, d1_q, d3_q, c3_q, c2_q, c1_q, k0_q, k2_q;
	logic signed [63:0] lin_q, u1_q, u2_q, u_q, pu_q, p_q, p1_q, ys_q, w_q, xs_q;

	// Result to send and output register.
	logic signed [63:0] resx_q;
	logic               resfin_q;
	logic [6:0]         resit_q;
	logic               mvalid_q;
	logic signed [63:0] mx_q;
	logic               mfin_q;
	logic [6:0]         mit_q;

	// Arithmetic unit hookup.
	cilm_pkg::alu_req_t  req;
	cilm_pkg::alu_op_t   op;
	logic signed [63:0]  opa, opb, alu_res;
	logic                alu_done;
	logic                calc;
	cilm_pkg::dst_t      dst;

	logic               accept;
	logic signed [63:0] fv;
	logic [63:0]        diff;
	logic [6:0]         pcnt_inc;
	logic [65:0]        cur3;
	logic               out_free;

	assign accept   = s_tvalid && s_tready;
	assign fv       = s_tdata;
	assign s_tready = (st_q == cilm_pkg::S_WAIT);
	assign out_free = !mvalid_q || m_tready;
	assign diff     = (xs_q >= prev_q) ? (64'(xs_q) - 64'(prev_q)) : (64'(prev_q) - 64'(xs_q));
	assign pcnt_inc = pcnt_q + 7'd1;
	assign cur3     = {2'b00, cur_q} + {1'b0, cur_q, 1'b0};

	cilm_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.a     (opa),
		.b     (opb),
		.done  (alu_done),
		.res   (alu_res)
	);

	assign req.start = calc && !issued_q;
	assign req.op    = op;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			istart_q <= 64'sd0;
			iend_q   <= 64'sd1 <<< FRAC_BITS;
			tol_q    <= 63'd4295;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START: istart_q <= cfg_data;
				REG_END:   iend_q   <= cfg_data;
				REG_TOL:   tol_q    <= cfg_data[62:0];
				default:   tol_q    <= tol_q;
			endcase
		end
	end

	// Sequencer: next state and arithmetic operation of each step.
	always_comb begin
		st_d = st_q;
		calc = 1'b0;
		op   = cilm_pkg::OP_ADD;
		opa  = ZERO;
		opb  = ZERO;
		dst  = cilm_pkg::D_TA;
		case (st_q)
			cilm_pkg::S_WAIT: begin
				if (accept) begin
					if (!s_tuser) st_d = cilm_pkg::S_LIM;
					else begin
						case (phase_q)
							cilm_pkg::PH_F0: st_d = cilm_pkg::S_EMIT;
							cilm_pkg::PH_F3: st_d = (plim_q == 7'd0) ? cilm_pkg::S_EMIT
								: cilm_pkg::S_TH0;
							cilm_pkg::PH_F1: st_d = cilm_pkg::S_TH0;
							cilm_pkg::PH_F2: st_d = cilm_pkg::S_C1;
							default:         st_d = cilm_pkg::S_EMIT;
						endcase
					end
				end
			end
			cilm_pkg::S_LIM: begin
				if (!((n_q < ITER_CAP) && (width_q > cur_q))) st_d = cilm_pkg::S_M0;
			end
			cilm_pkg::S_M0: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = br_q; opb = bl_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_M1;
			end
			cilm_pkg::S_M1: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = ta_q; opb = Q2;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_M2;
			end
			cilm_pkg::S_M2: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = bl_q; opb = ta_q;
				dst = cilm_pkg::D_PREV;
				if (alu_done) st_d = cilm_pkg::S_EMIT;
			end
			cilm_pkg::S_TH0: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = br_q; opb = bl_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_TH1;
			end
			cilm_pkg::S_TH1: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = ta_q; opb = Q3;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_TH2;
			end
			cilm_pkg::S_TH2: begin
				calc = 1'b1;
				op   = right_q ? cilm_pkg::OP_SUB : cilm_pkg::OP_ADD;
				opa  = right_q ? br_q : bl_q;
				opb  = ta_q;
				dst  = cilm_pkg::D_RESX;
				if (alu_done) st_d = cilm_pkg::S_EMIT;
			end
			// Sums and differences of the four values.
			cilm_pkg::S_C1: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = vi1_q; opb = f2_q;
				dst = cilm_pkg::D_S1;
				if (alu_done) st_d = cilm_pkg::S_C2;
			end
			cilm_pkg::S_C2: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = vl_q; opb = vr_q;
				dst = cilm_pkg::D_S3;
				if (alu_done) st_d = cilm_pkg::S_C3;
			end
			cilm_pkg::S_C3: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = f2_q; opb = vi1_q;
				dst = cilm_pkg::D_D1;
				if (alu_done) st_d = cilm_pkg::S_C4;
			end
			cilm_pkg::S_C4: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = vr_q; opb = vl_q;
				dst = cilm_pkg::D_D3;
				if (alu_done) st_d = cilm_pkg::S_C5;
			end
			// Polynomial coefficients.
			cilm_pkg::S_C5: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = d1_q; opb = K3;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_C6;
			end
			cilm_pkg::S_C6: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = d3_q; opb = ta_q;
				dst = cilm_pkg::D_C3;
				if (alu_done) st_d = cilm_pkg::S_C7;
			end
			cilm_pkg::S_C7: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = s3_q; opb = s1_q;
				dst = cilm_pkg::D_C2;
				if (alu_done) st_d = cilm_pkg::S_C8;
			end
			cilm_pkg::S_C8: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = d1_q; opb = K27;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_C9;
			end
			cilm_pkg::S_C9: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ta_q; opb = d3_q;
				dst = cilm_pkg::D_C1;
				if (alu_done) st_d = cilm_pkg::S_C10;
			end
			cilm_pkg::S_C10: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = s1_q; opb = K27;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_C11;
			end
			cilm_pkg::S_C11: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = s3_q; opb = K3;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_C12;
			end
			cilm_pkg::S_C12: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ta_q; opb = tb_q;
				dst = cilm_pkg::D_K0;
				if (alu_done) st_d = cilm_pkg::S_C13;
			end
			cilm_pkg::S_C13: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = c2_q; opb = K3;
				dst = cilm_pkg::D_K2;
				if (alu_done) st_d = cilm_pkg::S_BR;
			end
			// Pick cubic, quadratic or linear case.
			cilm_pkg::S_BR: begin
				if (cilm_pkg::mag(c3_q) > T3) st_d = cilm_pkg::S_D0;
				else if (cilm_pkg::mag(c2_q) > T2) st_d = cilm_pkg::S_Q0;
				else st_d = cilm_pkg::S_Y;
			end
			// Cubic case: discriminant and both stationary points.
			cilm_pkg::S_D0: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = c2_q; opb = c2_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_D1;
			end
			cilm_pkg::S_D1: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = c1_q; opb = c3_q;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_D2;
			end
			cilm_pkg::S_D2: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = tb_q; opb = Q3;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_D3;
			end
			cilm_pkg::S_D3: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ta_q; opb = tb_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_D4;
			end
			cilm_pkg::S_D4: begin
				st_d = ta_q[63] ? cilm_pkg::S_Y : cilm_pkg::S_D5;
			end
			cilm_pkg::S_D5: begin
				calc = 1'b1; op = cilm_pkg::OP_SQRT; opa = ta_q;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_D6;
			end
			cilm_pkg::S_D6: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ZERO; opb = c2_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_D8;
			end
			cilm_pkg::S_D8: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = ta_q; opb = tb_q;
				dst = cilm_pkg::D_U1;
				if (alu_done) st_d = cilm_pkg::S_D9;
			end
			cilm_pkg::S_D9: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = u1_q; opb = c3_q;
				dst = cilm_pkg::D_U1;
				if (alu_done) st_d = cilm_pkg::S_D10;
			end
			cilm_pkg::S_D10: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ta_q; opb = tb_q;
				dst = cilm_pkg::D_U2;
				if (alu_done) st_d = cilm_pkg::S_D11;
			end
			cilm_pkg::S_D11: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = u2_q; opb = c3_q;
				dst = cilm_pkg::D_U2;
				if (alu_done) st_d = cilm_pkg::S_D12;
			end
			cilm_pkg::S_D12: st_d = cilm_pkg::S_P0;
			cilm_pkg::S_D13: st_d = cilm_pkg::S_P0;
			cilm_pkg::S_D14: st_d = cilm_pkg::S_Y;
			// Quadratic case.
			cilm_pkg::S_Q0: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = c2_q; opb = K6;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_Q1;
			end
			cilm_pkg::S_Q1: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = ZERO; opb = c1_q;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_Q2;
			end
			cilm_pkg::S_Q2: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = tb_q; opb = ta_q;
				dst = cilm_pkg::D_U;
				if (alu_done) st_d = cilm_pkg::S_Y;
			end
			cilm_pkg::S_Y:  st_d = cilm_pkg::S_P0;
			cilm_pkg::S_Y1: st_d = cilm_pkg::S_X0;
			// Horner evaluation of the fitted cubic at pu.
			cilm_pkg::S_P0: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = c3_q; opb = pu_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = cilm_pkg::S_P1;
			end
			cilm_pkg::S_P1: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = p_q; opb = k2_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = cilm_pkg::S_P2;
			end
			cilm_pkg::S_P2: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = p_q; opb = pu_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = cilm_pkg::S_P3;
			end
			cilm_pkg::S_P3: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = p_q; opb = c1_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = cilm_pkg::S_P4;
			end
			cilm_pkg::S_P4: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = p_q; opb = pu_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = cilm_pkg::S_P5;
			end
			cilm_pkg::S_P5: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = p_q; opb = k0_q;
				dst = cilm_pkg::D_P;
				if (alu_done) st_d = ret_q;
			end
			// Map the point back to the bracket.
			cilm_pkg::S_X0: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = br_q; opb = bl_q;
				dst = cilm_pkg::D_W;
				if (alu_done) st_d = cilm_pkg::S_X1;
			end
			cilm_pkg::S_X1: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = u_q; opb = Q3;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_X2;
			end
			cilm_pkg::S_X2: begin
				calc = 1'b1; op = cilm_pkg::OP_MULQ; opa = ta_q; opb = w_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_X3;
			end
			cilm_pkg::S_X3: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = ta_q; opb = Q6;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_X4;
			end
			cilm_pkg::S_X4: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = bl_q; opb = ta_q;
				dst = cilm_pkg::D_XS;
				if (alu_done) st_d = cilm_pkg::S_X5;
			end
			cilm_pkg::S_X5: begin
				st_d = (diff >= {1'b0, tol_q}) ? cilm_pkg::S_S0 : cilm_pkg::S_F0;
			end
			// Shrink the bracket to one third.
			cilm_pkg::S_S0: begin
				calc = 1'b1; op = cilm_pkg::OP_DIV; opa = w_q; opb = Q3;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_S1;
			end
			cilm_pkg::S_S1: begin
				calc = 1'b1; op = cilm_pkg::OP_ADD; opa = bl_q; opb = ta_q;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_S2;
			end
			cilm_pkg::S_S2: begin
				calc = 1'b1; op = cilm_pkg::OP_SUB; opa = br_q; opb = ta_q;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_S3;
			end
			cilm_pkg::S_S3: begin
				st_d = (pcnt_inc < plim_q) ? cilm_pkg::S_TH0 : cilm_pkg::S_F0;
			end
			// Final comparison against both ends.
			cilm_pkg::S_F0: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = vl_q; opb = K48;
				dst = cilm_pkg::D_TA;
				if (alu_done) st_d = cilm_pkg::S_F1;
			end
			cilm_pkg::S_F1: begin
				calc = 1'b1; op = cilm_pkg::OP_MULI; opa = vr_q; opb = K48;
				dst = cilm_pkg::D_TB;
				if (alu_done) st_d = cilm_pkg::S_F2;
			end
			cilm_pkg::S_F2: st_d = cilm_pkg::S_EMIT;
			cilm_pkg::S_EMIT: begin
				if (out_free) st_d = cilm_pkg::S_WAIT;
			end
			default: st_d = cilm_pkg::S_WAIT;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= cilm_pkg::S_WAIT;
			issued_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (calc && alu_done) issued_q <= 1'b0;
			else if (calc) issued_q <= 1'b1;
		end
	end

	// Search state, result registers and arithmetic results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cilm_pkg::PH_IDLE;
			bl_q     <= 64'sd0;
			br_q     <= 64'sd0;
			vl_q     <= 64'sd0;
			vr_q     <= 64'sd0;
			vi1_q    <= 64'sd0;
			prev_q   <= 64'sd0;
			pcnt_q   <= 7'd0;
			plim_q   <= 7'd0;
			mvalid_q <= 1'b0;
		end else begin
			// Output valid: set when a result is loaded, cleared when taken.
			if ((st_q == cilm_pkg::S_EMIT) && out_free) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			if (calc && alu_done) begin
				case (dst)
					cilm_pkg::D_TA:   ta_q <= alu_res;
					cilm_pkg::D_TB:   tb_q <= alu_res;
					cilm_pkg::D_S1:   s1_q <= alu_res;
					cilm_pkg::D_S3:   s3_q <= alu_res;
					cilm_pkg::D_D1:   d1_q <= alu_res;
					cilm_pkg::D_D3:   d3_q <= alu_res;
					cilm_pkg::D_C3:   c3_q <= alu_res;
					cilm_pkg::D_C2:   c2_q <= alu_res;
					cilm_pkg::D_C1:   c1_q <= alu_res;
					cilm_pkg::D_K0:   k0_q <= alu_res;
					cilm_pkg::D_K2:   k2_q <= alu_res;
					cilm_pkg::D_U1:   u1_q <= alu_res;
					cilm_pkg::D_U2:   u2_q <= alu_res;
					cilm_pkg::D_U:    u_q  <= alu_res;
					cilm_pkg::D_P:    p_q  <= alu_res;
					cilm_pkg::D_W:    w_q  <= alu_res;
					cilm_pkg::D_XS:   xs_q <= alu_res;
					cilm_pkg::D_PREV: prev_q <= alu_res;
					cilm_pkg::D_RESX: begin
						resx_q   <= alu_res;
						resfin_q <= 1'b0;
						resit_q  <= pcnt_q;
					end
					default: ta_q <= alu_res;
				endcase
			end
			case (st_q)
				cilm_pkg::S_WAIT: begin
					if (accept) begin
						if (!s_tuser) begin
							// New search: latch the interval and count passes.
							bl_q     <= istart_q;
							br_q     <= iend_q;
							width_q  <= (iend_q >= istart_q) ? (64'(iend_q) - 64'(istart_q))
								: (64'(istart_q) - 64'(iend_q));
							cur_q    <= {1'b0, tol_q};
							n_q      <= 7'd0;
							pcnt_q   <= 7'd0;
							phase_q  <= cilm_pkg::PH_F0;
							resx_q   <= istart_q;
							resfin_q <= 1'b0;
							resit_q  <= 7'd0;
						end else begin
							case (phase_q)
								cilm_pkg::PH_F0: begin
									vl_q     <= fv;
									phase_q  <= cilm_pkg::PH_F3;
									resx_q   <= br_q;
									resfin_q <= 1'b0;
									resit_q  <= 7'd0;
								end
								cilm_pkg::PH_F3: begin
									vr_q <= fv;
									if (plim_q == 7'd0) begin
										// No passes: answer the better end.
										prev_q   <= (vl_q < fv) ? bl_q : br_q;
										resx_q   <= (vl_q < fv) ? bl_q : br_q;
										resfin_q <= 1'b1;
										resit_q  <= pcnt_q;
										phase_q  <= cilm_pkg::PH_IDLE;
									end else begin
										phase_q <= cilm_pkg::PH_F1;
										right_q <= 1'b0;
									end
								end
								cilm_pkg::PH_F1: begin
									vi1_q   <= fv;
									phase_q <= cilm_pkg::PH_F2;
									right_q <= 1'b1;
								end
								cilm_pkg::PH_F2: begin
									f2_q  <= fv;
									lin_q <= (vl_q < vr_q) ? NQ3 : Q3;
								end
								default: begin
									// Value with no search running repeats the answer.
									phase_q  <= cilm_pkg::PH_IDLE;
									resx_q   <= prev_q;
									resfin_q <= 1'b1;
									resit_q  <= pcnt_q;
								end
							endcase
						end
					end
				end
				cilm_pkg::S_LIM: begin
					if ((n_q < ITER_CAP) && (width_q > cur_q)) begin
						cur_q <= (|cur3[65:64]) ? {64{1'b1}} : cur3[63:0];
						n_q   <= n_q + 7'd1;
					end else begin
						plim_q <= n_q;
					end
				end
				cilm_pkg::S_BR: begin
					if (!(cilm_pkg::mag(c3_q) > T3) && !(cilm_pkg::mag(c2_q) > T2)) begin
						u_q <= lin_q;
					end
				end
				cilm_pkg::S_D4: begin
					if (ta_q[63]) u_q <= lin_q;
				end
				cilm_pkg::S_D12: begin
					pu_q  <= u1_q;
					ret_q <= cilm_pkg::S_D13;
				end
				cilm_pkg::S_D13: begin
					p1_q  <= p_q;
					pu_q  <= u2_q;
					ret_q <= cilm_pkg::S_D14;
				end
				cilm_pkg::S_D14: begin
					u_q <= (p1_q < p_q) ? u1_q : u2_q;
				end
				cilm_pkg::S_Y: begin
					pu_q  <= u_q;
					ret_q <= cilm_pkg::S_Y1;
				end
				cilm_pkg::S_Y1: begin
					ys_q <= p_q;
				end
				cilm_pkg::S_S3: begin
					// tb holds the left third point, ta the right one.
					if (xs_q < tb_q) begin
						br_q <= tb_q;
						vr_q <= vi1_q;
					end else if (xs_q < ta_q) begin
						bl_q <= tb_q;
						vl_q <= vi1_q;
						br_q <= ta_q;
						vr_q <= f2_q;
					end else begin
						bl_q <= ta_q;
						vl_q <= f2_q;
					end
					prev_q <= xs_q;
					pcnt_q <= pcnt_inc;
					if (pcnt_inc < plim_q) begin
						phase_q <= cilm_pkg::PH_F1;
						right_q <= 1'b0;
					end
				end
				cilm_pkg::S_F2: begin
					if ((ys_q < ta_q) && (ys_q < tb_q)) begin
						prev_q <= xs_q;
						resx_q <= xs_q;
					end else begin
						prev_q <= (vl_q < vr_q) ? bl_q : br_q;
						resx_q <= (vl_q < vr_q) ? bl_q : br_q;
					end
					resfin_q <= 1'b1;
					resit_q  <= pcnt_q;
					phase_q  <= cilm_pkg::PH_IDLE;
				end
				cilm_pkg::S_EMIT: begin
					if (out_free) begin
						mx_q     <= resx_q;
						mfin_q   <= resfin_q;
						mit_q    <= resit_q;
					end
				end
				default: begin
					n_q <= n_q;
				end
			endcase
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {1'b0, mit_q, mx_q};
	assign m_tuser  = mfin_q;

`ifndef ASSERT_OFF
	// An accepted item holds off the next one until its result is queued.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is at work");

	// The arithmetic unit only answers a request that was issued.
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> issued_q)
		else $error("arithmetic result without a request");

	// The pass index never passes the cap.
	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[70:64] <= ITER_CAP))
		else $error("iteration index beyond the pass cap");
`endif

endmodule

// ===== bench/cubic_interpolation_line_minimizer_tb.sv =====
// ----------------------------------------------------------------------------
// Cubic interpolation line minimizer testbench
// The bench stands in for the function evaluator. It answers each abscissa
// query with the value of one of several test functions, and it predicts
// every result item with a bit-accurate fixed-point model of the search.
// Several interval and tolerance settings are covered, extremes included,
// under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module cubic_interpolation_line_minimizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB        = cilm_pkg::FRAC_BITS_DEF;
	localparam int PASS_MAX  = cilm_pkg::MAX_ITER_DEF;
	localparam int ITEMS     = 1200;
	localparam longint LIMIT = 8_000_000;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_TOL   = 2'd2;

	localparam bit ACT_START = 1'b0;
	localparam bit ACT_VALUE = 1'b1;

	// Kinds of test function used to answer the queries.
	typedef enum int {FN_BOWL, FN_CUBIC, FN_NOISE, FN_EXTREME, FN_VEE, FN_CAP} fn_kind_t;

	// One result item as the block should deliver it.
	typedef struct packed {
		logic signed [63:0] x;
		logic               fin;
		logic [6:0]         iter;
	} min_result_t;

	// Predicts the search and checks the result items in order.
	class minimizer_scoreboard;
		logic signed [63:0] cfg_start, cfg_end;
		logic [62:0]        cfg_tol;
		logic signed [63:0] br_l, br_r, v_l, v_r, v_in1, prev_sol;
		int                 pass_cnt, pass_lim;
		cilm_pkg::phase_t   phase;
		min_result_t        awaited[$];
		int                 errors;

		function new();
			cfg_start = '0;
			cfg_end = 64'sd1 <<< FB;
			cfg_tol = 63'd4295;
			br_l = '0; br_r = '0; v_l = '0; v_r = '0; v_in1 = '0; prev_sol = '0;
			pass_cnt = 0; pass_lim = 0;
			phase = cilm_pkg::PH_IDLE;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				REG_START: cfg_start = val;
				REG_END: cfg_end = val;
				REG_TOL: cfg_tol = val[62:0];
				default: ;
			endcase
		endfunction

		// Saturating fixed-point arithmetic.
		function logic [63:0] magn(logic signed [63:0] a);
			return a[63] ? 64'd0 - 64'(a) : 64'(a);
		endfunction

		function logic signed [63:0] sat_mag(bit neg, logic [127:0] m);
			if (neg) return (m > 128'h8000_0000_0000_0000) ? cilm_pkg::SMIN
				: 64'(64'd0 - m[63:0]);
			return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? cilm_pkg::SMAX : m[63:0];
		endfunction

		function logic signed [63:0] add(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) return s[64] ? cilm_pkg::SMIN : cilm_pkg::SMAX;
			return s[63:0];
		endfunction

		function logic signed [63:0] sub(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [64:0] s;
			s = {a[63], a} - {b[63], b};
			if (s[64] != s[63]) return s[64] ? cilm_pkg::SMIN : cilm_pkg::SMAX;
			return s[63:0];
		endfunction

		function logic signed [63:0] neg(logic signed [63:0] a);
			return (a == cilm_pkg::SMIN) ? cilm_pkg::SMAX : -a;
		endfunction

		function logic signed [63:0] mulk(logic signed [63:0] a, logic [63:0] k);
			return sat_mag(a[63], 128'(magn(a)) * 128'(k));
		endfunction

		function logic signed [63:0] mulq(logic signed [63:0] a, logic signed [63:0] b);
			logic [127:0] m;
			m = 128'(magn(a)) * 128'(magn(b)) + (128'd1 << (FB - 1));
			return sat_mag(a[63] ^ b[63], m >> FB);
		endfunction

		function logic signed [63:0] divq(logic signed [63:0] a, logic signed [63:0] b);
			logic [127:0] n, d;
			if (b == 0) return (a == 0) ? 64'sd0 : (a[63] ? cilm_pkg::SMIN : cilm_pkg::SMAX);
			d = 128'(magn(b));
			n = (128'(magn(a)) << FB) + (d >> 1);
			return sat_mag(a[63] ^ b[63], n / d);
		endfunction

		function logic signed [63:0] sqrtq(logic signed [63:0] v);
			logic [127:0] n;
			logic [63:0]  r, t;
			n = v[63] ? 128'd0 : (128'(v) << FB);
			r = '0;
			for (int i = 63; i >= 0; i--) begin
				t = r | (64'd1 << i);
				if (128'(t) * 128'(t) <= n) r = t;
			end
			return r;
		endfunction

		function logic signed [63:0] qc(int k);
			return 64'(k) << FB;
		endfunction

		function logic signed [63:0] limit_of(logic [63:0] t64);
			return (t64 + (64'd1 << (63 - FB))) >> (64 - FB);
		endfunction

		// Horner evaluation of 48 times the fitted cubic.
		function logic signed [63:0] cubic_at(logic signed [63:0] u, c3, k2, c1, k0);
			logic signed [63:0] acc;
			acc = add(mulq(c3, u), k2);
			acc = add(mulq(acc, u), c1);
			return add(mulq(acc, u), k0);
		endfunction

		function logic signed [63:0] third_point();
			return divq(sub(br_r, br_l), qc(3));
		endfunction

		function logic signed [63:0] better_end();
			return (v_l < v_r) ? br_l : br_r;
		endfunction

		function min_result_t answer(logic signed [63:0] x);
			min_result_t r;
			prev_sol = x;
			phase = cilm_pkg::PH_IDLE;
			r.x = x; r.fin = 1'b1; r.iter = 7'(pass_cnt);
			return r;
		endfunction

		// Next result after the fourth function value of a pass.
		function min_result_t fit_pass(logic signed [63:0] f2);
			logic signed [63:0] f0, f1, f3, s1, s3, d1, d3, c3, c2, c1, k0, k2, lin;
			logic signed [63:0] u, u1, u2, rt, disc, ys, xs, w, t, x1, x2;
			logic [63:0]        diff;
			min_result_t        r;
			f0 = v_l; f1 = v_in1; f3 = v_r;
			s1 = add(f1, f2); s3 = add(f0, f3); d1 = sub(f2, f1); d3 = sub(f3, f0);
			c3 = sub(d3, mulk(d1, 3));
			c2 = sub(s3, s1);
			c1 = sub(mulk(d1, 27), d3);
			k0 = sub(mulk(s1, 27), mulk(s3, 3));
			k2 = mulk(c2, 3);
			lin = (f0 < f3) ? neg(qc(3)) : qc(3);
			if (magn(c3) > magn(limit_of(64'd37660237078))) begin
				disc = sub(mulq(c2, c2), divq(mulq(c1, c3), qc(3)));
				if (disc < 0) begin
					u = lin;
				end else begin
					rt = sqrtq(disc);
					u1 = divq(add(neg(c2), rt), c3);
					u2 = divq(sub(neg(c2), rt), c3);
					u = (cubic_at(u1, c3, k2, c1, k0) < cubic_at(u2, c3, k2, c1, k0)) ? u1 : u2;
				end
			end else if (magn(c2) > magn(limit_of(64'd35962877333))) begin
				u = divq(neg(c1), mulk(c2, 6));
			end else begin
				u = lin;
			end
			ys = cubic_at(u, c3, k2, c1, k0);
			w = sub(br_r, br_l);
			xs = add(br_l, divq(mulq(add(u, qc(3)), w), qc(6)));
			diff = (xs >= prev_sol) ? 64'(xs) - 64'(prev_sol) : 64'(prev_sol) - 64'(xs);
			if (diff >= 64'(cfg_tol)) begin
				t = divq(w, qc(3));
				x1 = add(br_l, t);
				x2 = sub(br_r, t);
				if (xs < x1) begin
					br_r = x1; v_r = f1;
				end else if (xs < x2) begin
					br_l = x1; v_l = f1;
					br_r = x2; v_r = f2;
				end else begin
					br_l = x2; v_l = f2;
				end
				prev_sol = xs;
				pass_cnt++;
				if (pass_cnt < pass_lim) begin
					phase = cilm_pkg::PH_F1;
					r.x = add(br_l, third_point()); r.fin = 1'b0; r.iter = 7'(pass_cnt);
					return r;
				end
			end
			if (ys < mulk(v_l, 48) && ys < mulk(v_r, 48)) return answer(xs);
			return answer(better_end());
		endfunction

		// Notes an accepted input item and returns the result it should cause.
		function min_result_t note(bit act, logic signed [63:0] fv);
			logic [63:0] width, cur;
			min_result_t r;
			r.fin = 1'b0;
			r.iter = 7'(pass_cnt);
			if (act == ACT_START) begin
				width = (cfg_end >= cfg_start) ? 64'(cfg_end) - 64'(cfg_start)
				                               : 64'(cfg_start) - 64'(cfg_end);
				cur = 64'(cfg_tol);
				pass_lim = 0;
				while (pass_lim < PASS_MAX && width > cur) begin
					cur = (cur > 64'h5555_5555_5555_5555) ? '1 : cur * 3;
					pass_lim++;
				end
				br_l = cfg_start;
				br_r = cfg_end;
				prev_sol = add(br_l, divq(sub(br_r, br_l), qc(2)));
				pass_cnt = 0;
				phase = cilm_pkg::PH_F0;
				r.x = br_l; r.iter = '0;
			end else begin
				case (phase)
					cilm_pkg::PH_F0: begin
						v_l = fv;
						phase = cilm_pkg::PH_F3;
						r.x = br_r; r.iter = '0;
					end
					cilm_pkg::PH_F3: begin
						v_r = fv;
						if (pass_lim == 0) begin
							r = answer(better_end());
						end else begin
							phase = cilm_pkg::PH_F1;
							r.x = add(br_l, third_point());
						end
					end
					cilm_pkg::PH_F1: begin
						v_in1 = fv;
						phase = cilm_pkg::PH_F2;
						r.x = sub(br_r, third_point());
					end
					cilm_pkg::PH_F2: r = fit_pass(fv);
					default: begin
						// No search running: the last answer is repeated.
						phase = cilm_pkg::PH_IDLE;
						r.x = prev_sol; r.fin = 1'b1;
					end
				endcase
			end
			awaited.push_back(r);
			return r;
		endfunction

		// Compares an accepted result item with the oldest expectation.
		function void check(logic [71:0] data, logic user);
			min_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result item x=%h iter=%0d fin=%b", $time,
					data[63:0], data[70:64], user);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (data[63:0] !== e.x) begin
				$display("%0t: query_x expected %h actual %h", $time, e.x, data[63:0]);
				errors++;
			end
			if (data[70:64] !== e.iter) begin
				$display("%0t: iteration expected %0d actual %0d", $time, e.iter, data[70:64]);
				errors++;
			end
			if (user !== e.fin) begin
				$display("%0t: finished expected %b actual %b", $time, e.fin, user);
				errors++;
			end
			if (data[71] !== 1'b0) begin
				$display("%0t: pad bit expected 0 actual %b", $time, data[71]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	minimizer_scoreboard sb;
	int     sent;
	bit     hold_out;
	longint cycles;

	cubic_interpolation_line_minimizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Idle rate in percent for one side, by the stage of the run.
	function automatic int idle_pct(bit sender);
		if (sent < ITEMS / 3) return sender ? 26 : 77;
		if (sent < 2 * ITEMS / 3) return sender ? 77 : 26;
		return 0;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Function value at x for a test function centered on c.
	function automatic logic signed [63:0] evaluate(fn_kind_t kind, logic signed [63:0] x,
		logic signed [63:0] c);
		logic signed [63:0] d;
		d = sb.sub(x, c);
		case (kind)
			FN_BOWL: return sb.mulq(d, d);
			FN_CUBIC: return sb.sub(sb.mulq(sb.mulq(d, d), d), sb.mulk(d, 4));
			FN_NOISE: return rand64();
			FN_EXTREME: begin
				case ($urandom_range(3))
					0: return cilm_pkg::SMAX;
					1: return cilm_pkg::SMIN;
					2: return 64'sd0;
					default: return rand64();
				endcase
			end
			FN_VEE: return d[63] ? sb.neg(d) : d;
			default: return sb.neg(sb.mulq(d, d));
		endcase
	endfunction

	// Offers one input item and waits until the block takes it.
	task automatic offer(input bit act, input logic [63:0] fv, output min_result_t r);
		int pct;
		pct = idle_pct(1'b1);
		if (pct > 0 && $urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= fv;
		do @(posedge clk); while (!s_tready);
		r = sb.note(act, fv);
		sent++;
	endtask

	// One search: a start item, then values until the answer or a cut.
	task automatic run_search(input fn_kind_t kind, input int cut);
		min_result_t        r;
		logic signed [63:0] c;
		int                 steps;
		c = sb.add(sb.cfg_start,
			sb.mulq(sb.sub(sb.cfg_end, sb.cfg_start), {32'd0, $urandom}));
		offer(ACT_START, rand64(), r);
		steps = 0;
		while (!r.fin && !(cut > 0 && steps >= cut)) begin
			offer(ACT_VALUE, evaluate(kind, r.x, c), r);
			steps++;
		end
	endtask

	// Waits until every expected result has come.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges.
	task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
		input logic [62:0] tol);
		cfg_we <= 1'b1; cfg_index <= REG_START; cfg_data <= lo;
		@(posedge clk);
		sb.write_reg(REG_START, lo);
		cfg_index <= REG_END; cfg_data <= hi;
		@(posedge clk);
		sb.write_reg(REG_END, hi);
		cfg_index <= REG_TOL; cfg_data <= {1'b0, tol};
		@(posedge clk);
		sb.write_reg(REG_TOL, {1'b0, tol});
		cfg_we <= 1'b0;
	endtask

	function automatic fn_kind_t pick_kind();
		case ($urandom_range(9))
			0, 1, 2: return FN_BOWL;
			3, 4: return FN_CUBIC;
			5: return FN_NOISE;
			6: return FN_EXTREME;
			7, 8: return FN_VEE;
			default: return FN_CAP;
		endcase
	endfunction

	// Result side: check accepted items, then choose the next ready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
		m_tready <= !hold_out && ($urandom_range(99) >= idle_pct(1'b0));
	end

	// Long output stall so that the block fills up and stops taking items.
	initial begin
		hold_out = 1'b0;
		wait (sent >= 150);
		@(posedge clk);
		hold_out = 1'b1;
		repeat (3000) @(posedge clk);
		hold_out = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		min_result_t        r;
		logic signed [63:0] lo, hi;
		logic [62:0]        tol;
		int                 phase_idx, mark;
		sb = new();
		clk = 1'b0;
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a value with no search, default interval, restarts.
		offer(ACT_VALUE, cilm_pkg::SMAX, r);
		run_search(FN_BOWL, 0);
		offer(ACT_VALUE, cilm_pkg::SMIN, r);
		run_search(FN_EXTREME, 0);
		run_search(FN_BOWL, 3);
		run_search(FN_VEE, 1);
		run_search(FN_CUBIC, 0);

		// Interval settings: fixed extremes first, then random ones.
		for (phase_idx = 0; sent < ITEMS; phase_idx++) begin
			drain();
			case (phase_idx)
				0: begin lo = -(64'sd8 <<< FB); hi = 64'sd8 <<< FB; tol = 63'd1; end
				1: begin lo = cilm_pkg::SMIN; hi = cilm_pkg::SMAX; tol = '1; end
				2: begin lo = cilm_pkg::SMAX; hi = cilm_pkg::SMIN; tol = 63'd1; end
				3: begin lo = 64'sd5 <<< FB; hi = 64'sd5 <<< FB; tol = 63'd1; end
				4: begin lo = -(64'sd3 <<< FB); hi = 64'sd100 <<< FB; tol = 63'd1 << 40; end
				default: begin
					lo = $signed(rand64()) >>> $urandom_range(0, 40);
					hi = sb.add(lo, rand64() >> $urandom_range(8, 50));
					if ($urandom_range(4) == 0) hi = sb.sub(lo, rand64() >> $urandom_range(8, 50));
					tol = 63'(rand64() >> $urandom_range(20, 63)) | 63'd1;
				end
			endcase
			set_search(lo, hi, tol);
			mark = sent;
			while (sent < mark + 80 && sent < ITEMS) begin
				run_search(pick_kind(), ($urandom_range(14) == 0) ? $urandom_range(1, 6) : 0);
				if ($urandom_range(9) == 0) offer(ACT_VALUE, rand64(), r);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== cubic_interpolation_line_minimizer.f =====
src/cilm_pkg.sv
src/cilm_alu.sv
src/cubic_interpolation_line_minimizer.sv
bench/cubic_interpolation_line_minimizer_tb.sv
